FILE: sv/drrc_pkg.sv
package drrc_pkg;

  // command codes
  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_READ  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  // result codes
  typedef enum logic [2:0] {
    ST_TAKEN   = 3'd0,
    ST_STORED  = 3'd1,
    ST_DUP     = 3'd2,
    ST_LONG    = 3'd3,
    ST_READ    = 3'd4,
    ST_NOENTRY = 3'd5,
    ST_CLEARED = 3'd6
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data_byte;
    logic       last_byte;
    logic [3:0] entry_ordinal;
    logic [5:0] byte_offset;
  } item_t;

  typedef struct packed {
    status_e    status;
    logic [7:0] read_byte;
    logic [5:0] record_length;
    logic [4:0] entries_used;
  } result_t;

  // ram access issued in the transfer cycle
  typedef struct packed {
    logic       we;
    logic [7:0] waddr;
    logic [7:0] wdata;
    logic [7:0] raddr;
  } ram_ctrl_t;

  // broadcast to every cell in the execute cycle
  typedef struct packed {
    logic       cmp;
    logic       rec_end;
    logic       store;
    logic [7:0] data;
    logic [7:0] len_new;
    logic [7:0] wp;
    logic [7:0] used;
    logic [7:0] rd_slot;
    logic [7:0] rd_off;
  } cell_ctrl_t;

  // handed from cell to cell along the row
  typedef struct packed {
    logic       dup;
    logic [7:0] rbyte;
    logic [5:0] rlen;
  } chain_t;

endpackage

FILE: sv/drrc_ram.sv
module drrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 62,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: sv/drrc_cell.sv
module drrc_cell #(
  parameter int         PAYLOAD    = 62,
  parameter logic [7:0] INIT_SLOT  = 8'd0,
  parameter logic       INIT_SPARE = 1'b0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  drrc_pkg::ram_ctrl_t  ram_i,
  input  drrc_pkg::cell_ctrl_t ctrl_i,
  input  drrc_pkg::chain_t     chain_i,
  output drrc_pkg::chain_t     chain_o
);
  import drrc_pkg::*;

  localparam int AW = (PAYLOAD > 1) ? $clog2(PAYLOAD) : 1;

  logic [7:0] slot_q, slot_d;
  logic       spare_q, spare_d;
  logic [7:0] len_q, len_d;
  logic       match_q, match_d;
  logic [7:0] rdata;
  logic       valid, byte_eq, match_now, dup_hit, read_hit;

  // payload bytes of this bank, written only while it stages a record
  drrc_ram #(.WIDTH(8), .DEPTH(PAYLOAD)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_i.we && spare_q),
    .waddr_i (AW'(ram_i.waddr)),
    .wdata_i (ram_i.wdata),
    .raddr_i (AW'(ram_i.raddr)),
    .rdata_o (rdata)
  );

  // hit detection for this bank
  always_comb begin
    valid     = !spare_q && (slot_q < ctrl_i.used);
    byte_eq   = (rdata == ctrl_i.data);
    match_now = match_q && byte_eq;
    dup_hit   = valid && match_now && (len_q == ctrl_i.len_new);
    read_hit  = valid && (slot_q == ctrl_i.rd_slot);
  end

  // or the hits into the row
  always_comb begin
    chain_o     = chain_i;
    chain_o.dup = chain_i.dup | dup_hit;
    if (read_hit) begin
      chain_o.rlen  = chain_i.rlen | 6'(len_q);
      chain_o.rbyte = chain_i.rbyte | ((ctrl_i.rd_off < len_q) ? rdata : 8'd0);
    end
  end

  // bank ownership, length and running match flag
  always_comb begin
    slot_d  = slot_q;
    spare_d = spare_q;
    len_d   = len_q;
    match_d = match_q;
    if (ctrl_i.cmp) begin
      match_d = match_now;
    end
    if (ctrl_i.rec_end) begin
      match_d = 1'b1;
    end
    if (ctrl_i.store) begin
      if (spare_q) begin
        slot_d  = ctrl_i.wp;
        spare_d = 1'b0;
        len_d   = ctrl_i.len_new;
      end else if (slot_q == ctrl_i.wp) begin
        spare_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= INIT_SLOT;
      spare_q <= INIT_SPARE;
      len_q   <= '0;
      match_q <= 1'b1;
    end else begin
      slot_q  <= slot_d;
      spare_q <= spare_d;
      len_q   <= len_d;
      match_q <= match_d;
    end
  end

endmodule

FILE: sv/dedup_ring_record_cache.sv
// Deduplicating record ring.
// Command channel: item_i is taken at a clock edge where start is high and
// busy is low. Mode write stages one record byte; the byte marked last_byte
// decides the record: too long, duplicate of a held record, or stored into
// the next ring slot. Mode read returns one byte and the length of the k-th
// oldest record. Mode clear empties the ring and drops a staged record.
// Result channel: each transfer yields one result on result_o, shown with
// done_o high for exactly one cycle, the cycle after the execute cycle.
// A new command can be taken in that same cycle, but not in the execute
// cycle, while busy is high; the execute cycle waits on the registered
// read of the bank memories.
// The ring is a row of ENTRIES+1 cells, each owning one slot's byte memory;
// one spare cell stages the incoming record and takes over the slot on store.
// Every cell that holds a record checks its bytes against each incoming
// byte, so a duplicate is known in the execute cycle of the last byte.
// Reset empties the ring at once; no clearing pass is needed.
// The receiver cannot stall: a result not taken in its cycle is gone.
module dedup_ring_record_cache #(
  parameter int ENTRIES   = 16,
  parameter int SLOT_SIZE = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  drrc_pkg::item_t   item_i,
  output logic              done_o,
  output drrc_pkg::result_t result_o
);
  import drrc_pkg::*;

  localparam int PAYLOAD = SLOT_SIZE - 2;
  localparam int NC      = ENTRIES + 1;
  localparam int CW      = $clog2(PAYLOAD + 1);
  localparam int UW      = $clog2(ENTRIES + 1);
  localparam int SW      = $clog2(ENTRIES);

  state_e     state_q, state_d;
  item_t      cmd_q;
  logic [CW-1:0] count_q, count_d, count_new;
  logic       ovf_q, ovf_d, ovf_new;
  logic [SW-1:0] wp_q, wp_d, oldest, rd_slot;
  logic [UW-1:0] used_q, used_d;
  logic       accept;
  logic       done_q, done_d;
  result_t    res_q, res_d;
  ram_ctrl_t  ram_ctrl;
  cell_ctrl_t cell_ctrl;
  chain_t     chain [NC+1];
  logic [31:0] slot_sum;

  assign accept = start && !busy;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (start) state_d = S_EXEC;
      S_EXEC: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    busy = 1'b0;
    unique case (state_q)
      S_IDLE: busy = 1'b0;
      S_EXEC: busy = 1'b1;
      default: busy = 1'b0;
    endcase
  end

  // memory access in the transfer cycle
  always_comb begin
    ram_ctrl.we    = accept && (mode_e'(item_i.mode) == MODE_WRITE)
                     && (32'(count_q) < 32'(PAYLOAD));
    ram_ctrl.waddr = 8'(count_q);
    ram_ctrl.wdata = item_i.data_byte;
    ram_ctrl.raddr = (mode_e'(item_i.mode) == MODE_READ) ? 8'(item_i.byte_offset)
                                                          : 8'(count_q);
  end

  // read slot of the k-th oldest record
  always_comb begin
    oldest   = (32'(used_q) < 32'(ENTRIES)) ? '0 : wp_q;
    slot_sum = 32'(oldest) + 32'(cmd_q.entry_ordinal);
    if (slot_sum >= 32'(ENTRIES)) begin
      slot_sum = slot_sum - 32'(ENTRIES);
    end
    rd_slot = SW'(slot_sum);
  end

  // staging count after this byte
  always_comb begin
    count_new = count_q;
    ovf_new   = ovf_q;
    if (32'(count_q) < 32'(PAYLOAD)) begin
      count_new = count_q + 1'b1;
    end else begin
      ovf_new = 1'b1;
    end
  end

  // execute cycle: decide the result and update the ring
  always_comb begin
    count_d   = count_q;
    ovf_d     = ovf_q;
    wp_d      = wp_q;
    used_d    = used_q;
    done_d    = 1'b0;
    res_d     = '0;
    res_d.status = ST_NOENTRY;
    cell_ctrl = '0;
    cell_ctrl.data    = cmd_q.data_byte;
    cell_ctrl.len_new = 8'(count_new);
    cell_ctrl.wp      = 8'(wp_q);
    cell_ctrl.used    = 8'(used_q);
    cell_ctrl.rd_slot = 8'(rd_slot);
    cell_ctrl.rd_off  = 8'(cmd_q.byte_offset);
    if (state_q == S_EXEC) begin
      done_d = 1'b1;
      unique case (mode_e'(cmd_q.mode))
        MODE_WRITE: begin
          cell_ctrl.cmp = (32'(count_q) < 32'(PAYLOAD));
          if (!cmd_q.last_byte) begin
            res_d.status = ST_TAKEN;
            count_d = count_new;
            ovf_d   = ovf_new;
          end else begin
            cell_ctrl.rec_end = 1'b1;
            count_d = '0;
            ovf_d   = 1'b0;
            if (ovf_new) begin
              res_d.status = ST_LONG;
            end else if (chain[NC].dup) begin
              res_d.status = ST_DUP;
            end else begin
              res_d.status = ST_STORED;
              cell_ctrl.store = 1'b1;
              wp_d = (32'(wp_q) == 32'(ENTRIES - 1)) ? '0 : wp_q + 1'b1;
              if (32'(used_q) < 32'(ENTRIES)) begin
                used_d = used_q + 1'b1;
              end
            end
          end
        end
        MODE_READ: begin
          if (32'(cmd_q.entry_ordinal) < 32'(used_q)) begin
            res_d.status        = ST_READ;
            res_d.read_byte     = chain[NC].rbyte;
            res_d.record_length = chain[NC].rlen;
          end
        end
        MODE_CLEAR: begin
          res_d.status = ST_CLEARED;
          cell_ctrl.rec_end = 1'b1;
          count_d = '0;
          ovf_d   = 1'b0;
          wp_d    = '0;
          used_d  = '0;
        end
        default: res_d.status = ST_NOENTRY;
      endcase
      res_d.entries_used = 5'(used_d);
    end
  end

  // row of cells, the last one starts as the spare
  assign chain[0] = '0;
  for (genvar i = 0; i < NC; i++) begin : g_cell
    drrc_cell #(
      .PAYLOAD    (PAYLOAD),
      .INIT_SLOT  (8'(i)),
      .INIT_SPARE (i == ENTRIES)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ram_i   (ram_ctrl),
      .ctrl_i  (cell_ctrl),
      .chain_i (chain[i]),
      .chain_o (chain[i+1])
    );
  end

  // command capture and result register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= item_i;
    end
    res_q <= res_d;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      ovf_q   <= 1'b0;
      wp_q    <= '0;
      used_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
      wp_q    <= wp_d;
      used_q  <= used_d;
      done_q  <= done_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule
